// ===== src/dgrt_pkg.sv =====
// Shared types, constants and state encoding for the DAG global-EDF response-time test.
`default_nettype none
package dgrt_pkg;

  localparam int MAX_TASKS_DEF = 32;
  localparam int VAL_W = 32;
  localparam int RESP_W = 33;
  localparam int IDX_W = 5;
  localparam int M_W = 7;
  localparam int DIV_W = 40;
  localparam int DVS_W = 32;
  localparam int ACC_W = 40;
  localparam logic [RESP_W-1:0] MISS_MARGIN = RESP_W'(100);
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  typedef struct packed {
    logic [VAL_W-1:0] work_time;
    logic [VAL_W-1:0] release_period;
    logic [VAL_W-1:0] relative_deadline;
    logic [VAL_W-1:0] path_length;
    logic             last_task;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  task_index;
    logic [RESP_W-1:0] resp_time;
    logic              meets_deadline;
    logic              last_result;
    logic              set_schedulable;
  } out_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] work;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] deadline;
    logic [VAL_W-1:0] path;
  } task_rec_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_I,
    S_LAT_I,
    S_DIV0,
    S_ITER,
    S_K_RD,
    S_K_LAT,
    S_K_CM,
    S_CD_START,
    S_CD_WAIT,
    S_MUL,
    S_SAT,
    S_SUMDIV,
    S_SUMWAIT,
    S_OUT
  } state_t;

  function automatic logic [ACC_W-1:0] sat_acc(input logic [63:0] v);
    return (|v[63:ACC_W]) ? ACC_MAX : v[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/dag_gedf_response_time_test_core.sv =====
// Top level of the DAG global-EDF response-time test.
// Task records are taken one per cycle into a task memory until a record marked last_task,
// which is stored and starts the analysis; records beyond MAX_TASKS are dropped. The input
// stalls during analysis. Every division goes through one shared serial divider, and that
// divider sets the analysis time: each fixed-point iteration of task i costs, for every
// other loaded task, the division of its work by the processor count and two ceiling
// divisions by its period (a ceiling division is skipped when its operand or the period is
// zero). One result transfer is produced per analysed task, and the run ends at the first
// deadline miss or after the last task. The next set may be loaded while the final result
// still waits to be taken.
`default_nettype none
module dag_gedf_response_time_test_core #(
  parameter int MAX_TASKS = dgrt_pkg::MAX_TASKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [dgrt_pkg::M_W-1:0]    cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire dgrt_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output dgrt_pkg::out_item_t              out_data
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int VW = dgrt_pkg::VAL_W;
  localparam int RW = dgrt_pkg::RESP_W;
  localparam int XW = RW + 1;
  localparam int AC = dgrt_pkg::ACC_W;
  localparam int LW = 7;

  dgrt_pkg::state_t state, state_next;

  logic [dgrt_pkg::M_W-1:0] processor_count;
  logic [dgrt_pkg::M_W-1:0] proc_m;
  logic [CW-1:0] task_cnt;
  logic [CW-1:0] idx_i;
  logic [CW-1:0] idx_k;
  logic [AW-1:0] rd_addr;

  dgrt_pkg::task_rec_t task_mem [MAX_TASKS];
  dgrt_pkg::task_rec_t rd_task;
  logic [RW-1:0] resp_mem [MAX_TASKS];
  logic [RW-1:0] rd_resp;
  logic [MAX_TASKS-1:0] resp_vld;
  logic rd_vld;

  logic [VW-1:0] li, di, ck, tk, dk;
  logic [RW-1:0] rk, start_val, resp, result;
  logic [XW-1:0] x1, x2, xs;
  logic sel, ok, ovf;
  logic [AC-1:0] cq, w1, w_cur, w_min, sum;
  logic [63:0] prod;

  dgrt_pkg::div_req_t div_req;
  logic div_done;
  logic [dgrt_pkg::DIV_W-1:0] div_q;

  logic in_take, out_free, i_last;
  logic [RW-1:0] start_calc;
  logic [XW-1:0] x1_sum, x2_sum;
  logic [AC:0] sum_calc;
  logic [AC:0] nxt_calc;
  logic [VW-1:0] cmin;

  assign proc_m = (processor_count == '0) ? dgrt_pkg::M_W'(1) : processor_count;
  assign in_stall = (state != dgrt_pkg::S_LOAD);
  assign in_take = in_valid && (state == dgrt_pkg::S_LOAD);
  assign out_free = !out_valid || !out_stall;
  assign i_last = !ok || ((idx_i + CW'(1)) == task_cnt);

  assign cmin = (rd_task.work > rd_task.path) ? (rd_task.work - rd_task.path) : '0;
  assign start_calc = RW'(li) + RW'(div_q[VW-1:0]);
  assign x1_sum = XW'(resp) + XW'(rk);
  assign x2_sum = XW'(di) + XW'(rk);
  assign xs = sel ? x2 : x1;
  assign w_cur = ovf ? dgrt_pkg::ACC_MAX : dgrt_pkg::sat_acc(prod);
  assign w_min = (w1 < w_cur) ? w1 : w_cur;
  assign sum_calc = (AC + 1)'(sum) + (AC + 1)'(w_min);
  assign nxt_calc = (AC + 1)'(start_val) + (AC + 1)'(div_q);

  dgrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgrt_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_req.start = 1'b0;
    div_req.dividend = '0;
    div_req.divisor = dgrt_pkg::DVS_W'(proc_m);
    rd_addr = idx_k[AW-1:0];
    unique case (state)
      dgrt_pkg::S_LOAD: begin
        if (in_take && in_data.last_task) begin
          state_next = dgrt_pkg::S_RD_I;
        end
      end
      dgrt_pkg::S_RD_I: begin
        rd_addr = idx_i[AW-1:0];
        state_next = dgrt_pkg::S_LAT_I;
      end
      dgrt_pkg::S_LAT_I: begin
        div_req.start = 1'b1;
        div_req.dividend = dgrt_pkg::DIV_W'(cmin);
        state_next = dgrt_pkg::S_DIV0;
      end
      dgrt_pkg::S_DIV0: begin
        if (div_done) begin
          state_next = (start_calc > RW'(di)) ? dgrt_pkg::S_OUT : dgrt_pkg::S_ITER;
        end
      end
      dgrt_pkg::S_ITER: begin
        state_next = dgrt_pkg::S_K_RD;
      end
      dgrt_pkg::S_K_RD: begin
        if (idx_k == task_cnt) begin
          state_next = dgrt_pkg::S_SUMDIV;
        end else if (idx_k != idx_i) begin
          state_next = dgrt_pkg::S_K_LAT;
        end
      end
      dgrt_pkg::S_K_LAT: begin
        div_req.start = 1'b1;
        div_req.dividend = dgrt_pkg::DIV_W'(rd_task.work);
        state_next = dgrt_pkg::S_K_CM;
      end
      dgrt_pkg::S_K_CM: begin
        if (div_done) begin
          state_next = dgrt_pkg::S_CD_START;
        end
      end
      dgrt_pkg::S_CD_START: begin
        if (xs == '0 || tk == '0) begin
          state_next = dgrt_pkg::S_MUL;
        end else begin
          div_req.start = 1'b1;
          div_req.dividend = dgrt_pkg::DIV_W'(xs - XW'(1));
          div_req.divisor = tk;
          state_next = dgrt_pkg::S_CD_WAIT;
        end
      end
      dgrt_pkg::S_CD_WAIT: begin
        if (div_done) begin
          state_next = dgrt_pkg::S_MUL;
        end
      end
      dgrt_pkg::S_MUL: begin
        state_next = dgrt_pkg::S_SAT;
      end
      dgrt_pkg::S_SAT: begin
        state_next = sel ? dgrt_pkg::S_K_RD : dgrt_pkg::S_CD_START;
      end
      dgrt_pkg::S_SUMDIV: begin
        div_req.start = 1'b1;
        div_req.dividend = sum;
        state_next = dgrt_pkg::S_SUMWAIT;
      end
      dgrt_pkg::S_SUMWAIT: begin
        if (div_done) begin
          if (nxt_calc == (AC + 1)'(resp) || nxt_calc > (AC + 1)'(di)) begin
            state_next = dgrt_pkg::S_OUT;
          end else begin
            state_next = dgrt_pkg::S_ITER;
          end
        end
      end
      dgrt_pkg::S_OUT: begin
        if (out_free) begin
          state_next = i_last ? dgrt_pkg::S_LOAD : dgrt_pkg::S_RD_I;
        end
      end
      default: begin
        state_next = dgrt_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      processor_count <= dgrt_pkg::M_W'(1);
    end else if (cfg_write) begin
      processor_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && task_cnt < CW'(MAX_TASKS)) begin
      task_mem[task_cnt[AW-1:0]] <= '{work: in_data.work_time,
                                      period: in_data.release_period,
                                      deadline: in_data.relative_deadline,
                                      path: in_data.path_length};
    end
    rd_task <= task_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == dgrt_pkg::S_OUT && out_free && ok) begin
      resp_mem[idx_i[AW-1:0]] <= result;
    end
    rd_resp <= resp_mem[rd_addr];
    rd_vld <= resp_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_cnt <= '0;
      resp_vld <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_take && task_cnt < CW'(MAX_TASKS)) begin
        task_cnt <= task_cnt + CW'(1);
      end
      if (in_take && in_data.last_task) begin
        resp_vld <= '0;
      end else if (state == dgrt_pkg::S_OUT && out_free && ok) begin
        resp_vld[idx_i[AW-1:0]] <= 1'b1;
      end
      if (state == dgrt_pkg::S_OUT && out_free) begin
        out_valid <= 1'b1;
        if (i_last) begin
          task_cnt <= '0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dgrt_pkg::S_LOAD: begin
        idx_i <= '0;
      end
      dgrt_pkg::S_LAT_I: begin
        li <= rd_task.path;
        di <= rd_task.deadline;
      end
      dgrt_pkg::S_DIV0: begin
        if (div_done) begin
          start_val <= start_calc;
          resp <= start_calc;
          ok <= (start_calc <= RW'(di));
          result <= RW'(di) + dgrt_pkg::MISS_MARGIN;
        end
      end
      dgrt_pkg::S_ITER: begin
        idx_k <= '0;
        sum <= '0;
      end
      dgrt_pkg::S_K_RD: begin
        if (idx_k == idx_i) begin
          idx_k <= idx_k + CW'(1);
        end
      end
      dgrt_pkg::S_K_LAT: begin
        ck <= rd_task.work;
        tk <= rd_task.period;
        dk <= rd_task.deadline;
        rk <= rd_vld ? rd_resp : '0;
      end
      dgrt_pkg::S_K_CM: begin
        if (div_done) begin
          sel <= 1'b0;
          x1 <= (x1_sum > XW'(div_q[VW-1:0])) ? (x1_sum - XW'(div_q[VW-1:0])) : '0;
          x2 <= (x2_sum > XW'(dk)) ? (x2_sum - XW'(dk)) : '0;
        end
      end
      dgrt_pkg::S_CD_START: begin
        if (xs == '0) begin
          cq <= '0;
        end else if (tk == '0) begin
          cq <= dgrt_pkg::ACC_MAX;
        end
      end
      dgrt_pkg::S_CD_WAIT: begin
        if (div_done) begin
          cq <= div_q + AC'(1);
        end
      end
      dgrt_pkg::S_MUL: begin
        // A quotient above 32 bits is exact only for small work values; with larger work the
        // product already lies beyond every deadline.
        prod <= 64'(cq[VW-1:0]) * 64'(ck) +
                ((64'(cq[VW+1:VW]) * 64'(ck[LW-1:0])) << VW);
        ovf <= ((|cq[AC-1:VW+2]) || ((|cq[VW+1:VW]) && (|ck[VW-1:LW]))) && (|ck);
      end
      dgrt_pkg::S_SAT: begin
        if (!sel) begin
          w1 <= w_cur;
          sel <= 1'b1;
        end else begin
          sum <= sum_calc[AC] ? dgrt_pkg::ACC_MAX : sum_calc[AC-1:0];
          idx_k <= idx_k + CW'(1);
        end
      end
      dgrt_pkg::S_SUMWAIT: begin
        if (div_done) begin
          if (nxt_calc == (AC + 1)'(resp)) begin
            result <= resp;
          end else if (nxt_calc > (AC + 1)'(di)) begin
            ok <= 1'b0;
          end else begin
            resp <= RW'(nxt_calc);
          end
        end
      end
      dgrt_pkg::S_OUT: begin
        if (out_free) begin
          out_data.task_index <= dgrt_pkg::IDX_W'(idx_i);
          out_data.resp_time <= result;
          out_data.meets_deadline <= ok;
          out_data.last_result <= i_last;
          out_data.set_schedulable <= i_last && ok;
          idx_i <= idx_i + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/dgrt_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module dgrt_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dgrt_pkg::div_req_t        req,
  output logic                           done,
  output logic [dgrt_pkg::DIV_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(dgrt_pkg::DIV_W);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [dgrt_pkg::DVS_W-1:0]    rem;
  logic [dgrt_pkg::DVS_W-1:0]    dvs;
  logic [dgrt_pkg::DIV_W-1:0]    quo;
  logic [dgrt_pkg::DVS_W:0]      trial;
  logic                          fits;

  assign trial = {rem, quo[dgrt_pkg::DIV_W-1]};
  assign fits = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      cnt <= CNT_W'(dgrt_pkg::DIV_W - 1);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (fits) begin
        rem <= dgrt_pkg::DVS_W'(trial - {1'b0, dvs});
        quo <= {quo[dgrt_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[dgrt_pkg::DVS_W-1:0];
        quo <= {quo[dgrt_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/dgrt_chk.sv =====
// Port-level checker for the response-time test core, with its bind statement.
`default_nettype none
module dgrt_chk (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire dgrt_pkg::out_item_t out_data
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("A result is offered right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("A stalled result changed before its transfer.");

  a_miss_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.meets_deadline |-> out_data.last_result)
    else $error("A deadline miss did not end the run.");

  a_sched_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.set_schedulable |-> out_data.last_result && out_data.meets_deadline)
    else $error("Schedulable flag set on a result that is not a successful final one.");

endmodule

bind dag_gedf_response_time_test_core dgrt_chk u_dgrt_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
